[rtl/core/rsst_pkg.sv]
`timescale 1ns / 1ps
package rsst_pkg;

  localparam int MAX_LEAVES = 1024;
  localparam int NODE_DEPTH = 2 * MAX_LEAVES;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  // leaf count register and range end need one bit above the index (0..2047)
  localparam int LEAF_W     = NODE_AW;
  localparam int IDX_W      = $clog2(MAX_LEAVES);
  localparam int DATA_W     = 32;

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic load;
    logic add;
  } acc_ctrl_t;

endpackage

[rtl/core/rsst_ram.sv]
`timescale 1ns / 1ps
module rsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

[rtl/core/rsst_acc.sv]
`timescale 1ns / 1ps
// shared three-input adder with its accumulator
module rsst_acc (
  input  logic                        clk,
  input  rsst_pkg::acc_ctrl_t         ctrl,
  input  logic [rsst_pkg::DATA_W-1:0] load_val,
  input  logic [rsst_pkg::DATA_W-1:0] opnd_a,
  input  logic [rsst_pkg::DATA_W-1:0] opnd_b,
  output logic [rsst_pkg::DATA_W-1:0] sum,
  output logic [rsst_pkg::DATA_W-1:0] acc
);

  assign sum = acc + opnd_a + opnd_b;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= load_val;
    end else if (ctrl.add) begin
      acc <= sum;
    end
  end

endmodule

[rtl/core/rsst_seq.sv]
`timescale 1ns / 1ps
module rsst_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rsst_pkg::LEAF_W-1:0]  leaves,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic                         req_cmd,
  input  logic [rsst_pkg::IDX_W-1:0]   req_index,
  input  logic [rsst_pkg::LEAF_W-1:0]  req_end,
  input  logic [rsst_pkg::DATA_W-1:0]  req_value,
  output logic                         wr_en,
  output logic [rsst_pkg::NODE_AW-1:0] wr_addr,
  output logic [rsst_pkg::DATA_W-1:0]  wr_data,
  output logic [rsst_pkg::NODE_AW-1:0] rd_addr_a,
  input  logic [rsst_pkg::DATA_W-1:0]  rd_data_a,
  output logic [rsst_pkg::NODE_AW-1:0] rd_addr_b,
  input  logic [rsst_pkg::DATA_W-1:0]  rd_data_b,
  output rsst_pkg::acc_ctrl_t          acc_ctrl,
  output logic [rsst_pkg::DATA_W-1:0]  acc_load,
  output logic [rsst_pkg::DATA_W-1:0]  acc_a,
  output logic [rsst_pkg::DATA_W-1:0]  acc_b,
  input  logic [rsst_pkg::DATA_W-1:0]  acc_sum,
  output logic                         res_valid,
  input  logic                         res_ready
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LEAF  = 3'd2;
  localparam logic [2:0] ST_SET   = 3'd3;
  localparam logic [2:0] ST_QRY   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int AW = rsst_pkg::NODE_AW;

  logic [2:0]    state;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] p;
  logic [AW:0]   lo;
  logic [AW:0]   hi;
  logic          pend;
  logic          ma;
  logic          mb;
  logic [rsst_pkg::DATA_W-1:0] val_q;

  logic [AW-1:0]   parent;
  logic [AW-1:0]   stop;
  logic [AW-1:0]   idx_ext;
  logic            lo_lt_hi;
  logic            accept;

  assign parent   = p >> 1;
  assign idx_ext  = AW'(req_index);
  assign stop     = (req_end > leaves) ? leaves : req_end;
  assign lo_lt_hi = lo < hi;
  assign accept   = req_valid && req_ready;

  assign req_ready = state == ST_IDLE;
  assign res_valid = state == ST_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(rsst_pkg::NODE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (req_cmd == rsst_pkg::CMD_SET) begin
              // out-of-range set is dropped
              if (idx_ext < leaves) begin
                state <= ST_LEAF;
              end
            end else if (idx_ext < stop) begin
              pend  <= 1'b0;
              state <= ST_QRY;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_LEAF: begin
          if (p > AW'(1)) begin
            state <= ST_SET;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SET: begin
          if (parent <= AW'(1)) begin
            state <= ST_IDLE;
          end
        end
        ST_QRY: begin
          pend <= lo_lt_hi;
          if (!lo_lt_hi && !pend) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // index / border registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      p     <= idx_ext + leaves;
      lo    <= {1'b0, idx_ext} + {1'b0, leaves};
      hi    <= {1'b0, stop} + {1'b0, leaves};
      val_q <= req_value;
    end else if (state == ST_SET) begin
      p <= parent;
    end else if (state == ST_QRY && lo_lt_hi) begin
      ma <= lo[0];
      mb <= hi[0];
      lo <= (lo + (AW + 1)'(lo[0])) >> 1;
      hi <= hi >> 1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    unique case (state)
      ST_CLEAR: wr_en = 1'b1;
      ST_LEAF: begin
        wr_en   = 1'b1;
        wr_addr = p;
        wr_data = val_q;
      end
      ST_SET: begin
        wr_en   = 1'b1;
        wr_addr = parent;
        wr_data = acc_sum;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    rd_addr_a = lo[AW-1:0];
    if (state == ST_LEAF) begin
      rd_addr_a = p ^ AW'(1);
    end else if (state == ST_SET) begin
      rd_addr_a = parent ^ AW'(1);
    end
    rd_addr_b = AW'(hi - (AW + 1)'(1));
  end

  always_comb begin
    acc_ctrl.load = (state == ST_LEAF) ||
                    (state == ST_IDLE && accept && req_cmd == rsst_pkg::CMD_QUERY);
    acc_ctrl.add  = (state == ST_SET) || (state == ST_QRY && pend);
    acc_load      = (state == ST_LEAF) ? val_q : '0;
    acc_a         = '0;
    acc_b         = '0;
    if (state == ST_SET) begin
      acc_a = rd_data_a;
    end else begin
      if (ma) acc_a = rd_data_a;
      if (mb) acc_b = rd_data_b;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_writes_zero: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> wr_en && wr_data == '0)
    else $error("clear pass not writing zero");

  a_borders_ordered: assert property (@(posedge clk) disable iff (rst)
    state == ST_QRY |-> lo <= hi)
    else $error("query borders crossed");

  a_set_above_root: assert property (@(posedge clk) disable iff (rst)
    state == ST_SET |-> p > AW'(1))
    else $error("set walk past root");

  a_acc_ctrl_excl: assert property (@(posedge clk) disable iff (rst)
    !(acc_ctrl.load && acc_ctrl.add))
    else $error("accumulator load and add together");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QRY || state == ST_DONE || state == ST_IDLE) |-> !wr_en)
    else $error("node write outside set or clear");
`endif

endmodule

[rtl/core/range_sum_segment_tree.sv]
`timescale 1ns / 1ps
// Set: writes the leaf, then walks up the tree one level a cycle, rewriting each parent up to the root.
// Query: one tree level a cycle with two node reads, the last reads still added in after the walk ends;
// m_tvalid rises once the sum has passed ST_DONE into the result register.
// One request at a time: s_tready is low until the set walk ends or the query sum is handed to the result register.
// Reset (rst, synchronous) clears the 2048-word node RAM, one word a cycle:
// s_tready stays low until the clear pass ends; leaf_count resets to 1024.
module range_sum_segment_tree (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // index[9:0], range_end[20:10], value[52:21], zero pad
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // range_sum
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata  // leaf_count
);

  localparam int AW = rsst_pkg::NODE_AW;
  localparam int DW = rsst_pkg::DATA_W;
  localparam int LW = rsst_pkg::LEAF_W;
  localparam int IW = rsst_pkg::IDX_W;

  logic [LW-1:0] leaf_count;
  logic [LW-1:0] leaves;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic [DW-1:0] rd_data_a;
  logic [DW-1:0] rd_data_b;

  rsst_pkg::acc_ctrl_t acc_ctrl;
  logic [DW-1:0] acc_load;
  logic [DW-1:0] acc_a;
  logic [DW-1:0] acc_b;
  logic [DW-1:0] acc_sum;
  logic [DW-1:0] acc;

  logic res_valid;
  logic res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= LW'(rsst_pkg::MAX_LEAVES);
    end else if (cfg_we) begin
      leaf_count <= cfg_wdata;
    end
  end

  always_comb begin
    priority if (leaf_count == '0) begin
      leaves = LW'(1);
    end else if (leaf_count > LW'(rsst_pkg::MAX_LEAVES)) begin
      leaves = LW'(rsst_pkg::MAX_LEAVES);
    end else begin
      leaves = leaf_count;
    end
  end

  rsst_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .leaves    (leaves),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_cmd   (s_tuser),
    .req_index (s_tdata[IW-1:0]),
    .req_end   (s_tdata[IW+LW-1:IW]),
    .req_value (s_tdata[IW+LW+DW-1:IW+LW]),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b),
    .acc_ctrl  (acc_ctrl),
    .acc_load  (acc_load),
    .acc_a     (acc_a),
    .acc_b     (acc_b),
    .acc_sum   (acc_sum),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  rsst_acc u_acc (
    .clk      (clk),
    .ctrl     (acc_ctrl),
    .load_val (acc_load),
    .opnd_a   (acc_a),
    .opnd_b   (acc_b),
    .sum      (acc_sum),
    .acc      (acc)
  );

  rsst_ram #(
    .WIDTH (DW),
    .DEPTH (rsst_pkg::NODE_DEPTH)
  ) u_nodes (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  // result register frees the sequencer while the sum waits downstream
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= acc;
    end
  end

endmodule

[tb/range_sum_segment_tree_tb.sv]
`timescale 1ns / 1ps
module range_sum_segment_tree_tb;

  localparam int IW = rsst_pkg::IDX_W;
  localparam int LW = rsst_pkg::LEAF_W;
  localparam int DW = rsst_pkg::DATA_W;
  localparam int AW = rsst_pkg::NODE_AW;

  typedef struct packed {
    logic          cmd;
    logic [IW-1:0] idx;
    logic [LW-1:0] rend;
    logic [DW-1:0] val;
  } tree_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // index[9:0], range_end[20:10], value[52:21], zero pad
  logic        s_tuser = 1'b0; // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // range_sum
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0; // leaf_count

  range_sum_segment_tree dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow tree and leaf count register
  logic [DW-1:0] node_sum [0:rsst_pkg::NODE_DEPTH-1];
  logic [LW-1:0] leaf_cfg = 11'd1024;

  tree_req_t     req_queue [$];
  logic [DW-1:0] sum_expect [$];
  int            fail_count = 0;

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int tx_gap = 0;
  int tx_next_gap;
  bit tx_busy;
  int rx_wait = 0;
  int rx_next_wait;

  // long receiver hold, toggled from the stimulus side
  bit stall_req = 1'b0;
  bit stall_ack = 1'b0;
  int stall_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < rsst_pkg::NODE_DEPTH; k++) node_sum[AW'(k)] = '0;
  end

  function automatic int unsigned leaves_in_use();
    int unsigned n;
    n = 32'(leaf_cfg);
    if (n == 0) n = 1;
    if (n > rsst_pkg::MAX_LEAVES) n = rsst_pkg::MAX_LEAVES;
    return n;
  endfunction

  function automatic void tree_apply(tree_req_t r);
    int unsigned n, p, lo, hi;
    logic [DW-1:0] acc;
    n = leaves_in_use();
    if (r.cmd == rsst_pkg::CMD_SET) begin
      if (r.idx < n) begin
        p = r.idx + n;
        node_sum[AW'(p)] = r.val;
        while (p > 1) begin
          node_sum[AW'(p >> 1)] = node_sum[AW'(p)] + node_sum[AW'(p ^ 1)];
          p = p >> 1;
        end
      end
    end else begin
      acc = '0;
      lo = 32'(r.idx);
      hi = (r.rend > n) ? n : 32'(r.rend);
      if (lo < hi) begin
        lo = lo + n;
        hi = hi + n;
        while (lo < hi) begin
          if (lo & 1) begin
            acc = acc + node_sum[AW'(lo)];
            lo++;
          end
          if (hi & 1) begin
            hi--;
            acc = acc + node_sum[AW'(hi)];
          end
          lo = lo >> 1;
          hi = hi >> 1;
        end
      end
      sum_expect.push_back(acc);
    end
  endfunction

  function automatic void push_req(logic cmd, int unsigned idx, int unsigned rend,
                                   logic [DW-1:0] val);
    tree_req_t r;
    r.cmd  = cmd;
    r.idx  = IW'(idx);
    r.rend = LW'(rend);
    r.val  = val;
    req_queue.push_back(r);
  endfunction

  function automatic void push_random_req();
    tree_req_t r;
    int unsigned n;
    n = leaves_in_use();
    r.cmd = $urandom_range(0, 1) ? rsst_pkg::CMD_QUERY : rsst_pkg::CMD_SET;
    if ($urandom_range(0, 9) == 0) r.idx = IW'($urandom_range(0, rsst_pkg::MAX_LEAVES - 1));
    else r.idx = IW'($urandom_range(0, n - 1));
    case ($urandom_range(0, 9))
      0:       r.rend = LW'($urandom_range(0, 2047));
      1:       r.rend = LW'(r.idx);
      2:       r.rend = (r.idx == 0) ? '0 : LW'($urandom_range(0, r.idx - 1));
      default: r.rend = (r.idx < n) ? LW'($urandom_range(r.idx + 1, n))
                                    : LW'($urandom_range(0, 2047));
    endcase
    case ($urandom_range(0, 9))
      0:       r.val = 32'h8000_0000;
      1:       r.val = 32'h7fff_ffff;
      2:       r.val = 32'hffff_ffff;
      default: r.val = $urandom;
    endcase
    req_queue.push_back(r);
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      tx_next_gap = tx_gap;
      tx_busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        tree_apply(req_queue.pop_front());
        tx_busy = 1'b0;
        tx_next_gap = tx_calm ? 0 : $urandom_range(0, 14);
      end
      if (!tx_busy) begin
        if (tx_next_gap != 0) begin
          tx_next_gap--;
        end else if (req_queue.size() != 0) begin
          s_tdata <= {3'b000, req_queue[0].val, req_queue[0].rend, req_queue[0].idx};
          s_tuser <= req_queue[0].cmd;
          tx_busy = 1'b1;
        end
      end
      s_tvalid <= tx_busy;
      tx_gap   <= tx_next_gap;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_req != stall_ack) begin
      stall_left <= 400;
      stall_ack  <= stall_req;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else begin
      rx_next_wait = rx_wait;
      if (m_tvalid && m_tready) begin
        if (sum_expect.size() == 0) begin
          $display("%0t: range_sum with no query pending, expected none, actual %h",
                   $time, m_tdata);
          fail_count++;
        end else if (m_tdata !== sum_expect[0]) begin
          $display("%0t: range_sum mismatch, expected %h, actual %h",
                   $time, sum_expect[0], m_tdata);
          fail_count++;
          void'(sum_expect.pop_front());
        end else begin
          void'(sum_expect.pop_front());
        end
        rx_next_wait = rx_calm ? 0 : $urandom_range(0, 14);
      end else if (rx_next_wait != 0) begin
        rx_next_wait--;
      end
      rx_wait  <= rx_next_wait;
      m_tready <= (rx_next_wait == 0) && (stall_left == 0);
    end
  end

  task automatic drain();
    while (req_queue.size() != 0 || sum_expect.size() != 0 || s_tvalid)
      @(negedge clk);
    // a trailing set may still be walking the tree
    repeat (30) @(negedge clk);
  endtask

  task automatic write_leaves(logic [LW-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    leaf_cfg = v;
    @(negedge clk);
  endtask

  task automatic random_phase(logic [LW-1:0] lc, int count, bit hold);
    write_leaves(lc);
    tx_calm = hold ? 1'b1 : ($urandom_range(0, 2) == 0);
    rx_calm = ($urandom_range(0, 2) == 0);
    for (int k = 0; k < count; k++) push_random_req();
    if (hold) stall_req = ~stall_req;
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes under the reset leaf count
    push_req(rsst_pkg::CMD_SET, 0, 0, 32'h7fff_ffff);
    push_req(rsst_pkg::CMD_SET, 1023, 2047, 32'h8000_0000);
    push_req(rsst_pkg::CMD_SET, 1, 0, 32'hffff_ffff);
    push_req(rsst_pkg::CMD_SET, 512, 0, 32'h0000_0001);
    push_req(rsst_pkg::CMD_QUERY, 0, 1024, 32'hdead_beef);
    push_req(rsst_pkg::CMD_QUERY, 0, 2047, 32'h0);
    push_req(rsst_pkg::CMD_QUERY, 1023, 1024, 32'h0);
    push_req(rsst_pkg::CMD_QUERY, 5, 5, 32'h0);
    push_req(rsst_pkg::CMD_QUERY, 700, 3, 32'h0);
    push_req(rsst_pkg::CMD_QUERY, 0, 0, 32'h0);
    push_req(rsst_pkg::CMD_QUERY, 0, 2, 32'h0);
    drain();

    // set beyond the leaves, end saturation
    write_leaves(11'd5);
    push_req(rsst_pkg::CMD_SET, 7, 0, 32'h1234_5678);
    push_req(rsst_pkg::CMD_SET, 4, 0, 32'h8000_0000);
    push_req(rsst_pkg::CMD_QUERY, 0, 2047, 32'h0);
    push_req(rsst_pkg::CMD_QUERY, 3, 5, 32'h0);
    push_req(rsst_pkg::CMD_QUERY, 4, 5, 32'h0);
    drain();

    // zero leaf count acts as one
    write_leaves(11'd0);
    push_req(rsst_pkg::CMD_SET, 0, 0, 32'hcafe_f00d);
    push_req(rsst_pkg::CMD_SET, 1, 0, 32'h5555_5555);
    push_req(rsst_pkg::CMD_QUERY, 0, 1, 32'h0);
    push_req(rsst_pkg::CMD_QUERY, 0, 2047, 32'h0);
    drain();

    // oversized count acts as the maximum; old nodes read with no rebuild
    write_leaves(11'd2047);
    push_req(rsst_pkg::CMD_QUERY, 0, 1024, 32'h0);
    push_req(rsst_pkg::CMD_QUERY, 1, 1023, 32'h0);
    drain();

    random_phase(11'd1024, 60, 1'b0);
    random_phase(11'd1, 30, 1'b0);
    random_phase(11'd2, 40, 1'b0);
    random_phase(11'd3, 40, 1'b0);
    random_phase(11'd13, 50, 1'b0);
    random_phase(11'd1024, 40, 1'b1);
    random_phase(11'd64, 50, 1'b0);
    random_phase(11'd1000, 50, 1'b0);
    random_phase(11'd2047, 40, 1'b0);
    random_phase(11'd0, 20, 1'b0);
    random_phase(11'($urandom_range(1, 1024)), 50, 1'b0);
    random_phase(11'd1025, 40, 1'b0);

    if (sum_expect.size() != 0) begin
      $display("%0t: %0d range sums never returned, expected %h, actual none",
               $time, sum_expect.size(), sum_expect[0]);
      fail_count++;
    end
    if (fail_count == 0)
      $display("range_sum_segment_tree verification clean");
    else
      $display("range_sum_segment_tree verification failed");
    $finish;
  end

  initial begin
    #3ms;
    $display("range_sum_segment_tree verification failed");
    $finish;
  end

endmodule

[files.f]
rtl/core/rsst_pkg.sv
rtl/core/rsst_ram.sv
rtl/core/rsst_acc.sv
rtl/core/rsst_seq.sv
rtl/core/range_sum_segment_tree.sv
tb/range_sum_segment_tree_tb.sv
